// File: rtl/vex_memory_operand_address_decode_assert.svh
// ----------------------------------------------------------------------------
// VEX address decode assertion macros
// Shared concurrent assertion forms for the decoder checkers.
// ----------------------------------------------------------------------------
`ifndef VEX_MEMORY_OPERAND_ADDRESS_DECODE_ASSERT_SVH
`define VEX_MEMORY_OPERAND_ADDRESS_DECODE_ASSERT_SVH

// same-cycle implication, muted during reset
`define VMOAD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, muted during reset
`define VMOAD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, checked through reset
`define VMOAD_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/vmoad_pkg.sv
// ----------------------------------------------------------------------------
// VEX address decode package
// Item types, decoded operation type and opcode constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vmoad_pkg;

  localparam int unsigned GPR_COUNT = 16;
  localparam int unsigned GPR_WIDTH = 64;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  localparam logic [7:0] VEX2_PREFIX = 8'hC5;
  localparam logic [7:0] VEX3_PREFIX = 8'hC4;
  localparam logic [7:0] OPCODE_ADD  = 8'h58;

  localparam logic [1:0] MOD_NODISP = 2'd0;
  localparam logic [1:0] MOD_DISP8  = 2'd1;
  localparam logic [1:0] MOD_DISP32 = 2'd2;
  localparam logic [1:0] MOD_REG    = 2'd3;

  localparam logic [2:0] RM_SIB    = 3'd4;
  localparam logic [2:0] RM_DISP32 = 3'd5;
  localparam logic [3:0] IDX_NONE  = 4'd4;

  typedef struct packed {
    logic        cmd;
    logic [3:0]  reg_number;
    logic [63:0] reg_value;
    logic [63:0] insn_bytes_low;
    logic [15:0] insn_bytes_high;
  } in_item_t;

  typedef struct packed {
    logic        decoded_ok;
    logic [3:0]  insn_length;
    logic [63:0] fault_address;
  } out_item_t;

  // value holds the write data or the sign-extended displacement
  typedef struct packed {
    logic        is_write;
    logic        ok;
    logic [3:0]  len;
    logic        base_en;
    logic [3:0]  base_sel;
    logic        idx_en;
    logic [3:0]  idx_sel;
    logic [1:0]  scale;
    logic [63:0] value;
  } op_t;

endpackage

// File: rtl/vmoad_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vmoad_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/vmoad_front.sv
// ----------------------------------------------------------------------------
// VEX address decode front end
// Accepts items, parses prefix, ModRM, SIB and displacement into an op.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vmoad_front (
  input  logic                req_valid,
  output logic                req_stall,
  input  vmoad_pkg::in_item_t req,
  input  logic                q_full,
  output logic                push,
  output vmoad_pkg::op_t      op
);

  logic [7:0]  b [10];
  logic [7:0]  rel [6];
  logic        vex2, vex3, opc_ok, rx, rb, is_write;
  logic [7:0]  modrm, sib, d8;
  logic [31:0] d32;
  logic [1:0]  mode;
  logic [2:0]  rm_lo;
  logic        has_sib, no_base, fail;
  logic [3:0]  idx, base;
  logic [2:0]  disp_len;
  logic [63:0] disp;

  assign req_stall = q_full;
  assign push      = req_valid && !q_full;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      b[k] = req.insn_bytes_low[8*k +: 8];
    end
    b[8] = req.insn_bytes_high[7:0];
    b[9] = req.insn_bytes_high[15:8];

    vex2 = (b[0] == vmoad_pkg::VEX2_PREFIX);
    vex3 = (b[0] == vmoad_pkg::VEX3_PREFIX);
    for (int k = 0; k < 6; k++) begin
      rel[k] = vex3 ? b[k+4] : b[k+3];
    end
    opc_ok = vex3 ? (b[3] == vmoad_pkg::OPCODE_ADD) : (b[2] == vmoad_pkg::OPCODE_ADD);
    rx     = vex3 & ~b[1][6];
    rb     = vex3 & ~b[1][5];

    modrm   = rel[0];
    sib     = rel[1];
    mode    = modrm[7:6];
    rm_lo   = modrm[2:0];
    has_sib = (rm_lo == vmoad_pkg::RM_SIB);
    idx     = {rx, sib[5:3]};
    base    = has_sib ? {rb, sib[2:0]} : {rb, rm_lo};
    no_base = has_sib && (mode == vmoad_pkg::MOD_NODISP) &&
              (sib[2:0] == vmoad_pkg::RM_DISP32);

    fail = !(vex2 || vex3) || !opc_ok || (mode == vmoad_pkg::MOD_REG) ||
           ((mode == vmoad_pkg::MOD_NODISP) && (rm_lo == vmoad_pkg::RM_DISP32)) ||
           (no_base && (idx == vmoad_pkg::IDX_NONE));

    if (mode == vmoad_pkg::MOD_DISP8) begin
      disp_len = 3'd1;
    end else if ((mode == vmoad_pkg::MOD_DISP32) || no_base) begin
      disp_len = 3'd4;
    end else begin
      disp_len = 3'd0;
    end

    d8  = has_sib ? rel[2] : rel[1];
    d32 = has_sib ? {rel[5], rel[4], rel[3], rel[2]} : {rel[4], rel[3], rel[2], rel[1]};
    case (disp_len)
      3'd1:    disp = {{56{d8[7]}}, d8};
      3'd4:    disp = {{32{d32[31]}}, d32};
      default: disp = '0;
    endcase

    is_write = (req.cmd == vmoad_pkg::CMD_WRITE);

    op          = '0;
    op.is_write = is_write;
    if (is_write) begin
      op.base_sel = req.reg_number;
      op.value    = req.reg_value;
    end else if (!fail) begin
      op.ok       = 1'b1;
      op.len      = (vex3 ? 4'd5 : 4'd4) + {3'b0, has_sib} + {1'b0, disp_len};
      op.base_en  = !no_base;
      op.base_sel = base;
      op.idx_en   = has_sib && (idx != vmoad_pkg::IDX_NONE);
      op.idx_sel  = idx;
      op.scale    = has_sib ? sib[7:6] : 2'd0;
      op.value    = disp;
    end
  end

endmodule

// File: rtl/vmoad_queue.sv
// ----------------------------------------------------------------------------
// VEX address decode op queue
// Short FIFO between the front end and the execute side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vmoad_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  vmoad_pkg::op_t push_op,
  output logic           full,
  output logic           head_valid,
  input  logic           pop,
  output vmoad_pkg::op_t head_op
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  vmoad_pkg::op_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_op    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_op;
    end
  end

endmodule

// File: rtl/vmoad_back.sv
// ----------------------------------------------------------------------------
// VEX address decode back end
// Holds the register file, reads operands and forms the effective address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vmoad_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  vmoad_pkg::op_t       q_op,
  output logic                 pop,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output vmoad_pkg::out_item_t rsp
);

  localparam int unsigned AW = $clog2(vmoad_pkg::GPR_COUNT);

  logic [vmoad_pkg::GPR_COUNT-1:0] gpr_vld;
  logic                            s1_valid, s1_bvld, s1_ivld;
  vmoad_pkg::op_t                  s1_op;
  logic [vmoad_pkg::GPR_WIDTH-1:0] base_data, idx_data, base_term, idx_term, addr;
  logic                            out_ready, s1_take, wr_en;

  assign out_ready = !rsp_valid || !rsp_stall;
  assign s1_take   = !s1_valid || out_ready;
  assign pop       = q_valid && s1_take;
  assign wr_en     = pop && q_op.is_write;

  vmoad_ram #(.WIDTH(vmoad_pkg::GPR_WIDTH), .DEPTH(vmoad_pkg::GPR_COUNT)) u_base_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (q_op.base_sel[AW-1:0]),
    .wdata (q_op.value),
    .re    (pop),
    .raddr (q_op.base_sel[AW-1:0]),
    .rdata (base_data)
  );

  vmoad_ram #(.WIDTH(vmoad_pkg::GPR_WIDTH), .DEPTH(vmoad_pkg::GPR_COUNT)) u_idx_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (q_op.base_sel[AW-1:0]),
    .wdata (q_op.value),
    .re    (pop),
    .raddr (q_op.idx_sel[AW-1:0]),
    .rdata (idx_data)
  );

  always_comb begin
    base_term = (s1_op.base_en && s1_bvld) ? base_data : '0;
    idx_term  = (s1_op.idx_en && s1_ivld) ? (idx_data << s1_op.scale) : '0;
    addr      = base_term + idx_term + s1_op.value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gpr_vld   <= '0;
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        gpr_vld[q_op.base_sel[AW-1:0]] <= 1'b1;
      end
      if (s1_take) begin
        s1_valid <= q_valid;
      end
      if (out_ready) begin
        rsp_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_op   <= q_op;
      s1_bvld <= gpr_vld[q_op.base_sel[AW-1:0]];
      s1_ivld <= gpr_vld[q_op.idx_sel[AW-1:0]];
    end
    if (s1_valid && out_ready) begin
      rsp.decoded_ok    <= s1_op.ok;
      rsp.insn_length   <= s1_op.len;
      rsp.fault_address <= s1_op.is_write ? '0 : addr;
    end
  end

endmodule

// File: rtl/vex_memory_operand_address_decode.sv
// ----------------------------------------------------------------------------
// VEX memory operand address decode
// Register writes and VEX ModRM/SIB effective address decode.
//
//   channel  dir  handshake             item
//   req      in   req_valid/req_stall   cmd, reg_number, reg_value, insn bytes
//   rsp      out  rsp_valid/rsp_stall   decoded_ok, insn_length, fault_address
//
// One item per cycle sustained while rsp_stall is low; a result passes the
// queue slot, the register file read stage and the output register in turn.
// Reset clears the register file valid bits, so every register reads as zero.
// A stalled rsp fills the output and read stages, then the QUEUE_DEPTH-entry
// queue, and only then raises req_stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vex_memory_operand_address_decode #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  vmoad_pkg::in_item_t  req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output vmoad_pkg::out_item_t rsp
);

  vmoad_pkg::op_t front_op, head_op;
  logic           push, q_full, q_valid, pop;

  vmoad_front u_front (
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_full    (q_full),
    .push      (push),
    .op        (front_op)
  );

  vmoad_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (front_op),
    .full       (q_full),
    .head_valid (q_valid),
    .pop        (pop),
    .head_op    (head_op)
  );

  vmoad_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_op      (head_op),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// File: rtl/vmoad_checker.sv
// ----------------------------------------------------------------------------
// VEX address decode checker
// Port-level assertions, bound to the decoder top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "vex_memory_operand_address_decode_assert.svh"

module vmoad_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_stall,
  input vmoad_pkg::in_item_t  req,
  input logic                 rsp_valid,
  input logic                 rsp_stall,
  input vmoad_pkg::out_item_t rsp
);

  logic req_seen;

  assign req_seen = req_valid && !req_stall && (req.cmd == vmoad_pkg::CMD_DECODE);

  `VMOAD_ASSERT_NOW(a_fail_zero, rsp_valid && !rsp.decoded_ok, (rsp.insn_length == 4'd0) && (rsp.fault_address == '0), "failed or write item has nonzero length or address")
  `VMOAD_ASSERT_NOW(a_len_range, rsp_valid && rsp.decoded_ok, (rsp.insn_length >= 4'd4) && (rsp.insn_length <= 4'd10), "decoded length out of range")
  `VMOAD_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall && !req_seen, rsp_valid && $stable(rsp), "stalled item changed")
  `VMOAD_ASSERT_ALWAYS(a_rst_idle, rst, !rsp_valid, "item shown right after reset")

endmodule

bind vex_memory_operand_address_decode vmoad_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

// File: verif/tb_vex_memory_operand_address_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VEX memory operand address decode testbench
// Sends register writes and VEX decode items over the req channel, idles
// the req side and stalls the rsp side in random bursts, and checks every rsp item in
// order against a behavioral effective-address calculator.
// ----------------------------------------------------------------------------

module tb_vex_memory_operand_address_decode;

  localparam int unsigned RANDOM_ITEMS = 1330;
  localparam int unsigned LONG_HOLD    = 40;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned TIMEOUT_NS   = 10_000_000;

  typedef struct packed {
    vmoad_pkg::in_item_t  item;
    logic                 fixed;
    vmoad_pkg::out_item_t want;
  } dir_row_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  vmoad_pkg::in_item_t  req       = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  vmoad_pkg::out_item_t rsp;

  logic [63:0]          gpr_shadow [vmoad_pkg::GPR_COUNT];
  vmoad_pkg::out_item_t ea_results_due [$];
  dir_row_t             dir_rows [$];

  int unsigned mismatches    = 0;
  int unsigned n_results     = 0;
  int unsigned n_writes      = 0;
  int unsigned n_decode_ok   = 0;
  int unsigned n_req_stalled = 0;
  int unsigned total_items   = 0;
  int unsigned req_idle_pct  = 0;

  always #6 clk = ~clk;

  vex_memory_operand_address_decode i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  function automatic logic [7:0] insn_byte(input logic [79:0] ib, input int unsigned k);
    return (k < 10) ? ib[k*8 +: 8] : 8'h00;
  endfunction

  // Effective address and length of one item; write items update the shadow file.
  function automatic vmoad_pkg::out_item_t compute_effective_address(
      input vmoad_pkg::in_item_t it);
    vmoad_pkg::out_item_t r;
    logic [79:0] ib;
    logic [7:0]  opc, modrm, sib;
    logic [31:0] d32;
    logic        x_ext, b_ext, base_on, idx_on;
    logic [3:0]  base_r, idx_r;
    logic [1:0]  ss;
    int unsigned pos, disp_n;
    logic [63:0] disp, ea;
    r = '0;
    if (it.cmd == vmoad_pkg::CMD_WRITE) begin
      gpr_shadow[it.reg_number] = it.reg_value;
      return r;
    end
    ib = {it.insn_bytes_high, it.insn_bytes_low};
    x_ext = 1'b0;
    b_ext = 1'b0;
    if (ib[7:0] == vmoad_pkg::VEX2_PREFIX) begin
      opc = ib[23:16];
      pos = 3;
    end else if (ib[7:0] == vmoad_pkg::VEX3_PREFIX) begin
      opc = ib[31:24];
      x_ext = ~ib[14];
      b_ext = ~ib[13];
      pos = 4;
    end else begin
      return r;
    end
    if (opc != vmoad_pkg::OPCODE_ADD) return r;
    modrm = insn_byte(ib, pos);
    pos++;
    if (modrm[7:6] == vmoad_pkg::MOD_REG ||
        (modrm[7:6] == vmoad_pkg::MOD_NODISP && modrm[2:0] == vmoad_pkg::RM_DISP32))
      return r;
    base_on = 1'b1;
    base_r = {b_ext, modrm[2:0]};
    idx_on = 1'b0;
    idx_r = vmoad_pkg::IDX_NONE;
    ss = 2'd0;
    disp_n = (modrm[7:6] == vmoad_pkg::MOD_DISP8) ? 1 :
             (modrm[7:6] == vmoad_pkg::MOD_DISP32) ? 4 : 0;
    if (modrm[2:0] == vmoad_pkg::RM_SIB) begin
      sib = insn_byte(ib, pos);
      pos++;
      ss = sib[7:6];
      idx_r = {x_ext, sib[5:3]};
      idx_on = (idx_r != vmoad_pkg::IDX_NONE);
      base_r = {b_ext, sib[2:0]};
      if (modrm[7:6] == vmoad_pkg::MOD_NODISP && sib[2:0] == vmoad_pkg::RM_DISP32) begin
        // no base, disp32 follows; no index as well is unsupported
        if (!idx_on) return r;
        base_on = 1'b0;
        disp_n = 4;
      end
    end
    d32 = {insn_byte(ib, pos + 3), insn_byte(ib, pos + 2),
           insn_byte(ib, pos + 1), insn_byte(ib, pos)};
    case (disp_n)
      1: disp = {{56{d32[7]}}, d32[7:0]};
      4: disp = {{32{d32[31]}}, d32};
      default: disp = '0;
    endcase
    pos += disp_n;
    ea = disp;
    if (base_on) ea += gpr_shadow[base_r];
    if (idx_on) ea += gpr_shadow[idx_r] << ss;
    r.decoded_ok = 1'b1;
    r.insn_length = pos[3:0];
    r.fault_address = ea;
    return r;
  endfunction

  // bytes written in instruction order, first byte leftmost
  function automatic logic [79:0] in_order(input logic [79:0] v);
    logic [79:0] r;
    for (int k = 0; k < 10; k++) r[k*8 +: 8] = v[(9-k)*8 +: 8];
    return r;
  endfunction

  function automatic vmoad_pkg::in_item_t decode_item(input logic [79:0] ib);
    vmoad_pkg::in_item_t it;
    it.cmd = vmoad_pkg::CMD_DECODE;
    it.reg_number = 4'($urandom);
    it.reg_value = {$urandom, $urandom};
    it.insn_bytes_low = ib[63:0];
    it.insn_bytes_high = ib[79:64];
    return it;
  endfunction

  function automatic vmoad_pkg::in_item_t write_item(input logic [3:0] n,
                                                     input logic [63:0] v);
    vmoad_pkg::in_item_t it;
    it.cmd = vmoad_pkg::CMD_WRITE;
    it.reg_number = n;
    it.reg_value = v;
    it.insn_bytes_low = {$urandom, $urandom};
    it.insn_bytes_high = 16'($urandom);
    return it;
  endfunction

  function automatic vmoad_pkg::out_item_t rsp_of(input logic ok, input logic [3:0] len,
                                                  input logic [63:0] addr);
    vmoad_pkg::out_item_t r;
    r.decoded_ok = ok;
    r.insn_length = len;
    r.fault_address = addr;
    return r;
  endfunction

  function automatic vmoad_pkg::in_item_t random_item();
    logic [79:0] ib;
    logic [63:0] v;
    logic [7:0]  modrm;
    int unsigned opc_at, sel;
    ib = {16'($urandom), $urandom, $urandom};
    v = {$urandom, $urandom};
    sel = $urandom_range(99);
    if (sel < 20) begin
      case ($urandom_range(5))
        0: v = '0;
        1: v = '1;
        2: v = 64'($urandom_range(255));
        3: v = -64'($urandom_range(4096));
        default: ;
      endcase
      return write_item(4'($urandom), v);
    end
    if (sel < 88) begin
      // well-formed VEX sequence, random content
      if ($urandom_range(1)) begin
        ib[7:0] = vmoad_pkg::VEX3_PREFIX;
        opc_at = 3;
      end else begin
        ib[7:0] = vmoad_pkg::VEX2_PREFIX;
        opc_at = 2;
      end
      ib[opc_at*8 +: 8] = vmoad_pkg::OPCODE_ADD;
      modrm = ib[(opc_at+1)*8 +: 8];
      if (modrm[7:6] == vmoad_pkg::MOD_REG && $urandom_range(3) != 0)
        modrm[7:6] = 2'($urandom_range(2));
      if ($urandom_range(2) == 0) modrm[2:0] = vmoad_pkg::RM_SIB;
      ib[(opc_at+1)*8 +: 8] = modrm;
      if (modrm[2:0] == vmoad_pkg::RM_SIB && $urandom_range(3) == 0)
        ib[(opc_at+2)*8 +: 3] = vmoad_pkg::RM_DISP32;
    end else if (sel < 94) begin
      // good prefix, opcode left random
      ib[7:0] = $urandom_range(1) ? vmoad_pkg::VEX3_PREFIX : vmoad_pkg::VEX2_PREFIX;
    end
    return decode_item(ib);
  endfunction

  task automatic add_row(input vmoad_pkg::in_item_t it, input logic fixed,
                         input vmoad_pkg::out_item_t want);
    dir_rows.push_back({it, fixed, want});
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic drive_item(input vmoad_pkg::in_item_t it, input vmoad_pkg::out_item_t want);
    int unsigned gap;
    if (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
      gap = $urandom_range(1, 19);
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req <= it;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    ea_results_due.push_back(want);
    if (it.cmd == vmoad_pkg::CMD_WRITE) n_writes++;
    @(negedge clk);
  endtask

  task automatic drain_pause();
    req_valid <= 1'b0;
    while (ea_results_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : stimulus
    vmoad_pkg::out_item_t want;
    dir_row_t             row;
    for (int k = 0; k < vmoad_pkg::GPR_COUNT; k++) gpr_shadow[k] = '0;

    add_row(decode_item(in_order(80'hC5_F8_58_00_00_00_00_00_00_00)), 1'b1,
            rsp_of(1'b1, 4'd4, '0));
    add_row(decode_item(80'hFF_FF_FF_FF_FF_FF_FF_FF_FF_FF), 1'b1, rsp_of(1'b0, 4'd0, '0));
    add_row(decode_item(80'h00_00_00_00_00_00_00_00_00_00), 1'b1, rsp_of(1'b0, 4'd0, '0));
    add_row(decode_item(in_order(80'hC5_F8_59_00_00_00_00_00_00_00)), 1'b1,
            rsp_of(1'b0, 4'd0, '0));
    add_row(decode_item(in_order(80'hC4_E1_79_59_00_00_00_00_00_00)), 1'b1,
            rsp_of(1'b0, 4'd0, '0));
    add_row(decode_item(in_order(80'hC5_F8_58_C0_00_00_00_00_00_00)), 1'b1,
            rsp_of(1'b0, 4'd0, '0));
    add_row(decode_item(in_order(80'hC5_F8_58_05_11_22_33_44_00_00)), 1'b1,
            rsp_of(1'b0, 4'd0, '0));
    add_row(decode_item(in_order(80'hC4_C1_79_58_05_11_22_33_44_00)), 1'b1,
            rsp_of(1'b0, 4'd0, '0));
    add_row(decode_item(in_order(80'hC5_F8_58_04_25_00_00_00_00_00)), 1'b1,
            rsp_of(1'b0, 4'd0, '0));
    add_row(write_item(4'd0, '1), 1'b1, rsp_of(1'b0, 4'd0, '0));
    add_row(write_item(4'd15, 64'h8000_0000_0000_0000), 1'b1, rsp_of(1'b0, 4'd0, '0));
    add_row(write_item(4'd12, 64'h0123_4567_89AB_CDEF), 1'b1, rsp_of(1'b0, 4'd0, '0));
    add_row(write_item(4'd5, 64'h0000_0000_1000_0000), 1'b1, rsp_of(1'b0, 4'd0, '0));
    add_row(write_item(4'd4, 64'hFFFF_FFFF_0000_0001), 1'b1, rsp_of(1'b0, 4'd0, '0));
    add_row(write_item(4'd7, 64'h0000_0000_0000_0040), 1'b1, rsp_of(1'b0, 4'd0, '0));
    add_row(decode_item(in_order(80'hC4_A1_79_58_04_E0_00_00_00_00)), 1'b0, '0);
    add_row(decode_item(in_order(80'hC5_F8_58_04_7D_78_56_34_92_00)), 1'b0, '0);
    add_row(decode_item(in_order(80'hC5_F8_58_40_80_00_00_00_00_00)), 1'b0, '0);
    add_row(decode_item(in_order(80'hC4_01_79_58_84_FF_01_00_00_80)), 1'b0, '0);
    add_row(decode_item(in_order(80'hC5_78_58_85_FF_FF_FF_7F_00_00)), 1'b0, '0);
    add_row(decode_item(in_order(80'hC5_F8_58_44_25_10_00_00_00_00)), 1'b0, '0);
    add_row(decode_item(in_order(80'hC4_C1_79_58_47_7F_00_00_00_00)), 1'b0, '0);
    add_row(decode_item(in_order(80'hC5_F8_58_04_24_00_00_00_00_00)), 1'b0, '0);
    add_row(decode_item(in_order(80'hC4_81_79_58_0C_A4_00_00_00_00)), 1'b0, '0);
    total_items = dir_rows.size() + RANDOM_ITEMS;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      want = compute_effective_address(row.item);
      if (row.fixed) want = row.want;
      drive_item(row.item, want);
    end
    drain_pause();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 150 == 0) req_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(5, 20);
      // keep offering while the response side holds off
      if (i >= 250 && i < 450) req_idle_pct = 0;
      if (i + 200 >= RANDOM_ITEMS) req_idle_pct = 0;
      if (i == 700) drain_pause();
      row.item = random_item();
      drive_item(row.item, compute_effective_address(row.item));
    end

    req_valid <= 1'b0;
    while (ea_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d items: %0d register writes, %0d decoded addresses, %0d rejected",
             n_results, n_writes, n_decode_ok, n_results - n_writes - n_decode_ok);
    $display("req held back on %0d cycles, %0d mismatches", n_req_stalled, mismatches);
    if (mismatches == 0) begin
      $display("tb_vex_memory_operand_address_decode OK");
    end else begin
      $display("tb_vex_memory_operand_address_decode NOT OK");
    end
    $finish;
  end

  initial begin : rsp_side
    int unsigned stall_left, pct, next_pick;
    bit          hold_done;
    stall_left = 0;
    pct = 0;
    next_pick = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (n_results >= next_pick) begin
        next_pick = n_results + 150;
        pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(5, 20);
      end
      if (n_results + 200 >= total_items) pct = 0;
      if (!hold_done && n_results >= 300) begin
        hold_done = 1'b1;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && pct != 0 && $urandom_range(99) < pct) begin
        stall_left = $urandom_range(1, 19);
      end
      rsp_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  always @(posedge clk) begin : rsp_check
    vmoad_pkg::out_item_t want;
    if (req_valid && req_stall) n_req_stalled++;
    if (!rst && rsp_valid && !rsp_stall) begin
      n_results++;
      if (ea_results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected item: ok=%0b len=%0d addr=%h", $time,
                   rsp.decoded_ok, rsp.insn_length, rsp.fault_address);
      end else begin
        want = ea_results_due.pop_front();
        if (want.decoded_ok) n_decode_ok++;
        if (rsp.decoded_ok !== want.decoded_ok || rsp.insn_length !== want.insn_length ||
            rsp.fault_address !== want.fault_address) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] mismatch: ok %0b/%0b len %0d/%0d addr %h/%h (exp/act)", $time,
                     want.decoded_ok, rsp.decoded_ok, want.insn_length, rsp.insn_length,
                     want.fault_address, rsp.fault_address);
        end
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("tb_vex_memory_operand_address_decode NOT OK");
    $finish;
  end

endmodule
